// ===== hw/rtl/erle_pkg.sv =====
// ----------------------------------------------------------------------------
// erle_pkg
// Shared types and constants for the escape-token run-length stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package erle_pkg;

    localparam int POSITION_BITS_DEF = 16;

    localparam int BYTE_W    = 8;
    localparam int LIMIT_W   = 16;
    localparam int ADDR_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_TOKEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 1'b1;

    localparam logic [BYTE_W-1:0]  ESCAPE_TOKEN_RST = 8'd0;
    localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST = 16'd35840;

    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_TOKEN  = 2'd1;
    localparam logic [1:0] PH_COUNT  = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0]  escape_token;
        logic [LIMIT_W-1:0] output_limit;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] start_address;
        logic [BYTE_W-1:0] run_value;
        logic [BYTE_W-1:0] run_length;
        logic              buffer_full;
    } t_run;

endpackage

`default_nettype wire

// ===== hw/rtl/erle_cfg.sv =====
// ----------------------------------------------------------------------------
// erle_cfg
// Configuration registers: escape token and output limit.
// ----------------------------------------------------------------------------
`default_nettype none

module erle_cfg
    import erle_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.escape_token <= ESCAPE_TOKEN_RST;
            r_cfg.output_limit <= OUTPUT_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ESCAPE_TOKEN: r_cfg.escape_token <= i_cfg_data[BYTE_W-1:0];
                CFG_OUTPUT_LIMIT: r_cfg.output_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/erle_core.sv =====
// ----------------------------------------------------------------------------
// erle_core
// Input word register, decode state (phase, count, position) and the
// single-pass run computation.
// ----------------------------------------------------------------------------
`default_nettype none

module erle_core
    import erle_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  t_cfg                   i_cfg,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [BYTE_W-1:0] i_in_byte,
    input  wire logic              i_restart,
    input  wire logic              i_out_ready,
    output logic                   o_res_valid,
    output t_run                   o_res
);

    localparam int LW = (POSITION_BITS > LIMIT_W) ? POSITION_BITS : LIMIT_W;

    logic                     r_in_valid;
    logic [BYTE_W-1:0]        r_in_byte;
    logic                     r_in_restart;
    logic [1:0]               r_phase, n_phase;
    logic [BYTE_W-1:0]        r_count, n_count;
    logic [POSITION_BITS-1:0] r_pos, n_pos;

    logic                     proc, in_ready, full;
    logic [LW-1:0]            lim_ext, max_ext;
    logic [POSITION_BITS-1:0] lim, pos, room, cnt_ext, run_n, len, new_pos;
    logic [1:0]               ph;
    logic [BYTE_W-1:0]        cnt;

    assign proc     = r_in_valid & i_out_ready;
    assign in_ready = ~r_in_valid | proc;
    assign o_stall  = ~in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_in_byte    <= i_in_byte;
            r_in_restart <= i_restart;
        end
    end

    assign lim_ext = LW'(i_cfg.output_limit);
    assign max_ext = LW'({POSITION_BITS{1'b1}});
    assign lim     = (lim_ext > max_ext) ? POSITION_BITS'(max_ext)
                                         : POSITION_BITS'(lim_ext);

    assign ph      = r_in_restart ? PH_NORMAL : r_phase;
    assign cnt     = r_in_restart ? '0 : r_count;
    assign pos     = r_in_restart ? '0 : r_pos;
    assign full    = (pos >= lim);
    assign room    = lim - pos;
    assign cnt_ext = POSITION_BITS'(cnt);
    assign run_n   = (cnt_ext > room) ? room : cnt_ext;
    assign len     = (ph == PH_COUNT) ? run_n : POSITION_BITS'(1);
    assign new_pos = pos + len;

    always_comb begin
        n_phase             = r_phase;
        n_count             = r_count;
        n_pos               = r_pos;
        o_res_valid         = 1'b0;
        o_res.start_address = ADDR_W'(pos);
        o_res.run_value     = r_in_byte;
        o_res.run_length    = BYTE_W'(len);
        o_res.buffer_full   = (new_pos >= lim);
        if (proc) begin
            n_phase = ph;
            n_count = cnt;
            n_pos   = pos;
            if (!full) begin
                unique case (ph)
                    PH_TOKEN: begin
                        n_count = r_in_byte;
                        n_phase = PH_COUNT;
                    end
                    PH_COUNT: begin
                        n_phase = PH_NORMAL;
                        if (run_n != '0) begin
                            o_res_valid = 1'b1;
                            n_pos       = new_pos;
                        end
                    end
                    default: begin
                        if (r_in_byte == i_cfg.escape_token) begin
                            n_phase = PH_TOKEN;
                        end else begin
                            n_phase     = PH_NORMAL;
                            o_res_valid = 1'b1;
                            n_pos       = new_pos;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_pos   <= n_pos;
        end
    end

`ifndef SYNTHESIS
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.run_length != '0))
        else $error("run emitted with zero length");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && !r_in_restart && full) |=> ($stable(r_phase) && $stable(r_pos)))
        else $error("state changed while buffer full");

    a_token_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && ph == PH_TOKEN) |-> !o_res_valid)
        else $error("result emitted on count byte");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (new_pos <= lim))
        else $error("run exceeds output limit");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/erle_out.sv =====
// ----------------------------------------------------------------------------
// erle_out
// Result word register toward the downstream channel.
// ----------------------------------------------------------------------------
`default_nettype none

module erle_out
    import erle_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_res_valid,
    input  t_run      i_res,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_run      o_res
);

    logic r_valid;
    t_run r_res;

    assign o_ready = ~r_valid | ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// ===== hw/rtl/escape_rle_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// escape_rle_stream_decoder
// Escape-token run-length decoder: one compressed byte in, zero or one run
// record (address, value, length, full flag) out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | in        | i_valid / o_stall  | i_in_byte, i_restart
//  out     | out       | o_valid / i_stall  | o_start_address, o_run_value,
//          |           |                    | o_run_length, o_buffer_full
//  cfg     | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
//  One byte per cycle sustained while the output does not stall; a byte's run
//  passes through the input register, then the result register, before it can
//  be taken downstream.
//  The decode state (phase, count, position) is computed combinationally and registered.
//  Synchronous active-low reset clears state, valids and config to defaults.
//  A stall on the output backs up through the result and input registers.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_rle_stream_decoder
    import erle_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [BYTE_W-1:0]    i_in_byte,
    input  wire logic                 i_restart,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [ADDR_W-1:0]         o_start_address,
    output logic [BYTE_W-1:0]         o_run_value,
    output logic [BYTE_W-1:0]         o_run_length,
    output logic                      o_buffer_full,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg cfg;
    t_run res, out_res;
    logic res_valid, out_ready;

    erle_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    erle_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_byte   (i_in_byte),
        .i_restart   (i_restart),
        .i_out_ready (out_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    erle_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_ready     (out_ready),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (out_res)
    );

    assign o_start_address = out_res.start_address;
    assign o_run_value     = out_res.run_value;
    assign o_run_length    = out_res.run_length;
    assign o_buffer_full   = out_res.buffer_full;

endmodule

`default_nettype wire
